[sv/lcs_pkg.sv]
package lcs_pkg;

   // default configuration
   localparam int MAX_LEN_DEF     = 64;
   localparam int SYMBOL_BITS_DEF = 8;

   // fixed port widths
   localparam int SYM_PORT_W = 8;
   localparam int LEN_PORT_W = 7;

   typedef enum logic [1:0] {
      CMD_LOAD_FIRST  = 2'd0,
      CMD_LOAD_SECOND = 2'd1,
      CMD_RUN         = 2'd2
   } cmd_type;

   // traceback direction stored per cell
   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_LEFT = 2'd1,
      DIR_DIAG = 2'd2
   } dir_type;

endpackage

[sv/lcs_length_and_backtrack.sv]
// A load request is taken while idle and leaves busy low.
// A run fills the table row by row (a row-setup step, then one cell per cycle per row),
// then traces back (a read state, then a step state, per traceback step), then emits the result strobes.
// The fill rate is set by the single read port of the score row memory.
// Results cannot be stalled. Reset (synchronous) empties both strings and clears the drop flag.
module lcs_length_and_backtrack import lcs_pkg::*; #(
   parameter int MAX_LEN     = MAX_LEN_DEF,
   parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [SYM_PORT_W-1:0] req_symbol,
   output logic                  rsp_valid,
   output logic [SYM_PORT_W-1:0] rsp_lcs_symbol,
   output logic                  rsp_has_symbol,
   output logic [LEN_PORT_W-1:0] rsp_lcs_length,
   output logic                  rsp_overflow,
   output logic                  rsp_last
);

   localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int DEPTH_D = MAX_LEN * MAX_LEN;
   localparam int DAW     = (DEPTH_D > 1) ? $clog2(DEPTH_D) : 1;
   localparam int SW      = (SYMBOL_BITS < SYM_PORT_W) ? SYMBOL_BITS : SYM_PORT_W;
   localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);
   localparam logic [DAW-1:0]   ROW_STEP  = DAW'(MAX_LEN);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,      // row setup: fetch a[i], issue column 0
      S_FILL,     // one cell per cycle
      S_TB_RD,    // traceback: read direction mark and a[i]
      S_TB_EV,    // traceback: take the step
      S_EMIT_RD,  // read stacked symbol
      S_EMIT_OUT, // present it
      S_EMPTY     // single empty result
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_a_ff, len_a_in;
   logic [LEN_W-1:0] len_b_ff, len_b_in;
   logic             drop_ff, drop_in;

   // fill control
   logic [AW-1:0]    row_ff, row_in;
   logic [AW-1:0]    col_ff, col_in;         // next column to issue
   logic [AW-1:0]    pend_col_ff, pend_col_in; // column being computed
   logic             pend_last_ff, pend_last_in;
   logic             first_row_ff, first_row_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] diag_ff, diag_in;
   logic [DAW-1:0]   dir_base_ff, dir_base_in; // row * MAX_LEN, reused by traceback
   logic [LEN_W-1:0] total_ff, total_in;

   // traceback / emit
   logic [LEN_W-1:0] tb_i_ff, tb_i_in;
   logic [LEN_W-1:0] tb_j_ff, tb_j_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    emit_ptr_ff, emit_ptr_in;

   // registered response
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_PORT_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [LEN_PORT_W-1:0] rsp_len_ff, rsp_len_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_last_ff, rsp_last_in;

   // memory ports
   logic             a_we, b_we, score_we, dir_we, rev_we;
   logic [AW-1:0]    a_raddr, b_raddr, score_raddr;
   logic [SW-1:0]    a_rdata, b_rdata, rev_rdata;
   logic [LEN_W-1:0] score_rdata;
   logic [DAW-1:0]   dir_waddr, dir_raddr;
   logic [1:0]       dir_rdata;
   dir_type          dir_q;

   // cell
   logic [LEN_W-1:0] up_val;
   logic [LEN_W-1:0] cell_score;
   dir_type          cell_dir;

   // helpers
   logic [LEN_W-1:0] len_a_dec, len_b_dec, tb_i_dec, tb_j_dec;
   logic [LEN_W-1:0] i_nx, j_nx, cnt_nx, cnt_nx_dec;
   logic             accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign len_a_dec = len_a_ff - 1'b1;
   assign len_b_dec = len_b_ff - 1'b1;
   assign tb_i_dec  = tb_i_ff - 1'b1;
   assign tb_j_dec  = tb_j_ff - 1'b1;

   assign a_raddr     = (state_ff == S_TB_RD) ? tb_i_dec[AW-1:0] : row_ff;
   assign b_raddr     = (state_ff == S_ROW) ? '0 : col_ff;
   assign score_raddr = b_raddr;
   assign dir_waddr   = dir_base_ff + DAW'(pend_col_ff);
   assign dir_raddr   = dir_base_ff + DAW'(tb_j_dec[AW-1:0]);
   assign dir_q       = dir_type'(dir_rdata);

   // first row sees an all-zero row above it
   assign up_val = first_row_ff ? '0 : score_rdata;

   lcs_ram #(.DEPTH(MAX_LEN), .WIDTH(SW)) u_first_mem (
      .clock (clock),
      .we    (a_we),
      .waddr (len_a_ff[AW-1:0]),
      .wdata (req_symbol[SW-1:0]),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   lcs_ram #(.DEPTH(MAX_LEN), .WIDTH(SW)) u_second_mem (
      .clock (clock),
      .we    (b_we),
      .waddr (len_b_ff[AW-1:0]),
      .wdata (req_symbol[SW-1:0]),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   // one score row, overwritten in place as the next row is computed
   lcs_ram #(.DEPTH(MAX_LEN), .WIDTH(LEN_W)) u_score_mem (
      .clock (clock),
      .we    (score_we),
      .waddr (pend_col_ff),
      .wdata (cell_score),
      .raddr (score_raddr),
      .rdata (score_rdata)
   );

   lcs_ram #(.DEPTH(DEPTH_D), .WIDTH(2)) u_dir_mem (
      .clock (clock),
      .we    (dir_we),
      .waddr (dir_waddr),
      .wdata (cell_dir),
      .raddr (dir_raddr),
      .rdata (dir_rdata)
   );

   // matched symbols, pushed in reverse order, popped forward
   lcs_ram #(.DEPTH(MAX_LEN), .WIDTH(SW)) u_rev_mem (
      .clock (clock),
      .we    (rev_we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (a_rdata),
      .raddr (emit_ptr_ff),
      .rdata (rev_rdata)
   );

   lcs_cell #(.SW(SW), .LEN_W(LEN_W)) u_cell (
      .a_sym (a_rdata),
      .b_sym (b_rdata),
      .up    (up_val),
      .left  (left_ff),
      .diag  (diag_ff),
      .score (cell_score),
      .dir   (cell_dir)
   );

   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      drop_in      = drop_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pend_col_in  = pend_col_ff;
      pend_last_in = pend_last_ff;
      first_row_in = first_row_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      dir_base_in  = dir_base_ff;
      total_in     = total_ff;
      tb_i_in      = tb_i_ff;
      tb_j_in      = tb_j_ff;
      cnt_in       = cnt_ff;
      emit_ptr_in  = emit_ptr_ff;
      rsp_valid_in = 1'b0;
      rsp_sym_in   = rsp_sym_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      a_we         = 1'b0;
      b_we         = 1'b0;
      score_we     = 1'b0;
      dir_we       = 1'b0;
      rev_we       = 1'b0;
      i_nx         = tb_i_ff;
      j_nx         = tb_j_ff;
      cnt_nx       = cnt_ff;
      cnt_nx_dec   = cnt_ff - 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD_FIRST: begin
                     if (len_a_ff < MAX_LEN_L) begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  CMD_LOAD_SECOND: begin
                     if (len_b_ff < MAX_LEN_L) begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     total_in = '0;
                     if (len_a_ff == '0 || len_b_ff == '0) begin
                        state_in = S_EMPTY;
                     end else begin
                        row_in       = '0;
                        dir_base_in  = '0;
                        first_row_in = 1'b1;
                        state_in     = S_ROW;
                     end
                  end
                  default: ; // unused code: ignored
               endcase
            end
         end

         S_ROW: begin
            col_in       = AW'(1);
            pend_col_in  = '0;
            pend_last_in = (len_b_ff == LEN_W'(1));
            left_in      = '0;
            diag_in      = '0;
            state_in     = S_FILL;
         end

         S_FILL: begin
            score_we     = 1'b1;
            dir_we       = 1'b1;
            left_in      = cell_score;
            diag_in      = up_val;
            pend_col_in  = col_ff;
            pend_last_in = (LEN_W'(col_ff) == len_b_dec);
            col_in       = col_ff + 1'b1;
            if (pend_last_ff) begin
               total_in = cell_score;
               if (LEN_W'(row_ff) == len_a_dec) begin
                  tb_i_in  = len_a_ff;
                  tb_j_in  = len_b_ff;
                  cnt_in   = '0;
                  state_in = S_TB_RD;
               end else begin
                  row_in       = row_ff + 1'b1;
                  dir_base_in  = dir_base_ff + ROW_STEP;
                  first_row_in = 1'b0;
                  state_in     = S_ROW;
               end
            end
         end

         S_TB_RD: begin
            state_in = S_TB_EV;
         end

         S_TB_EV: begin
            case (dir_q)
               DIR_DIAG: begin
                  rev_we      = 1'b1;
                  cnt_nx      = cnt_ff + 1'b1;
                  i_nx        = tb_i_dec;
                  j_nx        = tb_j_dec;
                  dir_base_in = dir_base_ff - ROW_STEP;
               end
               DIR_UP: begin
                  i_nx        = tb_i_dec;
                  dir_base_in = dir_base_ff - ROW_STEP;
               end
               default: begin
                  j_nx = tb_j_dec;
               end
            endcase
            cnt_nx_dec = cnt_nx - 1'b1;
            tb_i_in    = i_nx;
            tb_j_in    = j_nx;
            cnt_in     = cnt_nx;
            if (i_nx == '0 || j_nx == '0) begin
               if (cnt_nx == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  emit_ptr_in = cnt_nx_dec[AW-1:0];
                  state_in    = S_EMIT_RD;
               end
            end else begin
               state_in = S_TB_RD;
            end
         end

         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end

         S_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_sym_in   = SYM_PORT_W'(rev_rdata);
            rsp_has_in   = 1'b1;
            rsp_len_in   = LEN_PORT_W'(total_ff);
            rsp_ovf_in   = drop_ff;
            rsp_last_in  = (emit_ptr_ff == '0);
            if (emit_ptr_ff == '0) begin
               len_a_in = '0;
               len_b_in = '0;
               drop_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               emit_ptr_in = emit_ptr_ff - 1'b1;
               state_in    = S_EMIT_RD;
            end
         end

         S_EMPTY: begin
            rsp_valid_in = 1'b1;
            rsp_sym_in   = '0;
            rsp_has_in   = 1'b0;
            rsp_len_in   = '0;
            rsp_ovf_in   = drop_ff;
            rsp_last_in  = 1'b1;
            len_a_in     = '0;
            len_b_in     = '0;
            drop_in      = 1'b0;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      col_ff       <= col_in;
      pend_col_ff  <= pend_col_in;
      pend_last_ff <= pend_last_in;
      first_row_ff <= first_row_in;
      left_ff      <= left_in;
      diag_ff      <= diag_in;
      dir_base_ff  <= dir_base_in;
      total_ff     <= total_in;
      tb_i_ff      <= tb_i_in;
      tb_j_ff      <= tb_j_in;
      cnt_ff       <= cnt_in;
      emit_ptr_ff  <= emit_ptr_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lcs_symbol = rsp_sym_ff;
   assign rsp_has_symbol = rsp_has_ff;
   assign rsp_lcs_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign rsp_last       = rsp_last_ff;

   // a strobe only ever follows a cycle of work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response strobe without a run in progress");

   // an empty result is a single item of length zero
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_symbol |-> rsp_last && (rsp_lcs_length == '0))
      else $error("malformed empty response");

   // a symbol item carries a nonzero length
   a_sym_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_symbol |-> (rsp_lcs_length != '0))
      else $error("symbol response with zero length");

   // a run request makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_RUN) |=> busy)
      else $error("run request did not start work");

endmodule

[sv/lcs_ram.sv]
// simple dual-port RAM, registered read
module lcs_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/lcs_cell.sv]
// one DP cell: score and direction from its three neighbors
module lcs_cell import lcs_pkg::*; #(
   parameter int SW    = SYMBOL_BITS_DEF,
   parameter int LEN_W = 7
) (
   input  logic [SW-1:0]    a_sym,
   input  logic [SW-1:0]    b_sym,
   input  logic [LEN_W-1:0] up,
   input  logic [LEN_W-1:0] left,
   input  logic [LEN_W-1:0] diag,
   output logic [LEN_W-1:0] score,
   output dir_type          dir
);

   always_comb begin
      if (a_sym == b_sym) begin
         score = diag + 1'b1;
         dir   = DIR_DIAG;
      end else if (up >= left) begin
         score = up;
         dir   = DIR_UP;
      end else begin
         score = left;
         dir   = DIR_LEFT;
      end
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import lcs_pkg::*;

   // Unused command code: accepted by the handshake, then ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         STR_DEPTH  = MAX_LEN_DEF;
   localparam int         SHORT_LEN  = 8;
   localparam logic [7:0] SYM_MASK   = 8'((1 << SYMBOL_BITS_DEF) - 1);

   // One result strobe, flattened in port order.
   typedef struct packed {
      logic [7:0] sym;
      logic       has_sym;
      logic [6:0] lcs_len;
      logic       overflow;
      logic       last;
   } lcs_result_type;

   // Directed row: a request, plus a hand-written result where it is obvious.
   typedef struct packed {
      logic [1:0]     cmd;
      logic [7:0]     sym;
      logic           typed;
      lcs_result_type res;
   } stim_row_type;

   localparam lcs_result_type NO_RES    = '0;
   localparam lcs_result_type EMPTY_RES = '{8'h00, 1'b0, 7'd0, 1'b0, 1'b1};
   localparam int             NUM_ROWS  = 27;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_cmd = CMD_LOAD_FIRST;
   logic [7:0] req_symbol = 8'h00;
   logic       busy;
   logic       rsp_valid;
   logic [7:0] rsp_lcs_symbol;
   logic       rsp_has_symbol;
   logic [6:0] rsp_lcs_length;
   logic       rsp_overflow;
   logic       rsp_last;

   lcs_length_and_backtrack dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_symbol    (req_symbol),
      .rsp_valid     (rsp_valid),
      .rsp_lcs_symbol(rsp_lcs_symbol),
      .rsp_has_symbol(rsp_has_symbol),
      .rsp_lcs_length(rsp_lcs_length),
      .rsp_overflow  (rsp_overflow),
      .rsp_last      (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor state: the two strings, their lengths, the drop flag
   // and the DP working tables.
   // ---------------------------------------------------------------
   logic [7:0]  first_syms  [STR_DEPTH];
   logic [7:0]  second_syms [STR_DEPTH];
   int unsigned first_len  = 0;
   int unsigned second_len = 0;
   bit          drop_seen  = 1'b0;
   dir_type     dir_mark [STR_DEPTH][STR_DEPTH];
   int unsigned score    [STR_DEPTH+1][STR_DEPTH+1];

   lcs_result_type run_results     [$];   // strobes caused by the latest request
   lcs_result_type expected_subseq [$];   // strobes still owed by the block

   int unsigned requests_sent = 0;
   int unsigned runs_sent     = 0;
   int unsigned drops_seen    = 0;
   int unsigned strobes_seen  = 0;
   int unsigned mismatches    = 0;
   int unsigned idle_pct      = 0;
   bit          start_req     = 1'b0;   // level start was last driven to

   lcs_result_type got_res;
   lcs_result_type want_res;

   // Advance the string state by one request; fills run_results.
   function automatic void predict_lcs(logic [1:0] cmd, logic [7:0] sym);
      int unsigned    m, n, i, j, k, total, count;
      logic [7:0]     rev [STR_DEPTH];
      lcs_result_type r;
      logic [7:0]     s;
      s = sym & SYM_MASK;
      total = 0;
      count = 0;
      run_results.delete();
      case (cmd)
         CMD_LOAD_FIRST: begin
            if (first_len < STR_DEPTH) begin
               first_syms[first_len] = s;
               first_len++;
            end else begin
               drop_seen = 1'b1;
               drops_seen++;
            end
         end
         CMD_LOAD_SECOND: begin
            if (second_len < STR_DEPTH) begin
               second_syms[second_len] = s;
               second_len++;
            end else begin
               drop_seen = 1'b1;
               drops_seen++;
            end
         end
         CMD_RUN: begin
            m = first_len;
            n = second_len;
            if (m > 0 && n > 0) begin
               for (j = 0; j <= n; j++) score[0][j] = 0;
               for (i = 1; i <= m; i++) begin
                  score[i][0] = 0;
                  for (j = 1; j <= n; j++) begin
                     // match wins; on a tie between up and left, up wins
                     if (first_syms[i-1] == second_syms[j-1]) begin
                        score[i][j] = score[i-1][j-1] + 1;
                        dir_mark[i-1][j-1] = DIR_DIAG;
                     end else if (score[i-1][j] >= score[i][j-1]) begin
                        score[i][j] = score[i-1][j];
                        dir_mark[i-1][j-1] = DIR_UP;
                     end else begin
                        score[i][j] = score[i][j-1];
                        dir_mark[i-1][j-1] = DIR_LEFT;
                     end
                  end
               end
               total = score[m][n];
            end
            // walk back from the corner, collecting matches in reverse
            i = m;
            j = n;
            while (i > 0 && j > 0 && count < STR_DEPTH) begin
               if (dir_mark[i-1][j-1] == DIR_DIAG) begin
                  rev[count] = first_syms[i-1];
                  count++;
                  i--;
                  j--;
               end else if (dir_mark[i-1][j-1] == DIR_UP) begin
                  i--;
               end else begin
                  j--;
               end
            end
            if (count == 0) begin
               r = EMPTY_RES;
               r.overflow = drop_seen;
               run_results.push_back(r);
            end else begin
               for (k = 0; k < count; k++) begin
                  r.sym      = rev[count-1-k];
                  r.has_sym  = 1'b1;
                  r.lcs_len  = total[6:0];
                  r.overflow = drop_seen;
                  r.last     = (k + 1 == count);
                  run_results.push_back(r);
               end
            end
            first_len  = 0;
            second_len = 0;
            drop_seen  = 1'b0;
         end
         default: ;   // unused code: no effect
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Sender side. start is driven from a shadow bit so that it never
   // gets two nonblocking writes in one time step.
   // ---------------------------------------------------------------
   task automatic lower_start();
      if (start_req) begin
         start <= 1'b0;
         start_req = 1'b0;
      end
   endtask

   // Present one request and hold it until the block takes it.
   task automatic send_request(logic [1:0] cmd, logic [7:0] sym,
                               logic typed = 1'b0, lcs_result_type typed_res = NO_RES);
      req_cmd    <= cmd;
      req_symbol <= sym;
      if (!start_req) begin
         start <= 1'b1;
         start_req = 1'b1;
      end
      do @(posedge clock); while (busy !== 1'b0);
      requests_sent++;
      if (cmd == CMD_RUN) runs_sent++;
      predict_lcs(cmd, sym);
      if (typed) expected_subseq.push_back(typed_res);
      else foreach (run_results[q]) expected_subseq.push_back(run_results[q]);
   endtask

   // Random sender idling: each cycle idles with probability idle_pct percent.
   task automatic sender_gap();
      while ($urandom_range(99) < idle_pct) begin
         lower_start();
         @(posedge clock);
      end
   endtask

   // Pause until every owed strobe has arrived (bounded).
   task automatic drain_expected();
      int unsigned waited;
      lower_start();
      for (waited = 0; expected_subseq.size() != 0 && waited < 20000; waited++)
         @(posedge clock);
   endtask

   // One load/run sequence. Symbols come from a tiny random alphabet so
   // matches are common; noise and early runs break some sequences.
   // full_size fills the first string to the brim, pushes one extra symbol
   // into it to force a drop, then loads a short second string from the
   // same pattern.
   task automatic send_sequence(bit full_size);
      logic [7:0]  alphabet [3];
      logic [7:0]  pattern  [STR_DEPTH];
      int unsigned want_first, want_second, done_first, done_second, k;
      for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(255));
      if (full_size) begin
         for (k = 0; k < STR_DEPTH; k++) begin
            pattern[k] = alphabet[$urandom_range(2)];
            send_request(CMD_LOAD_FIRST, pattern[k]);
            sender_gap();
         end
         send_request(CMD_LOAD_FIRST, 8'($urandom_range(255)));
         for (k = 0; k < SHORT_LEN; k++) begin
            send_request(CMD_LOAD_SECOND, pattern[k]);
            sender_gap();
         end
      end else begin
         want_first  = $urandom_range(0, 6);
         want_second = $urandom_range(0, 6);
         done_first  = 0;
         done_second = 0;
         while (done_first < want_first || done_second < want_second) begin
            if ($urandom_range(9) == 0) begin
               send_request(CMD_UNUSED, 8'($urandom_range(255)));
            end else if ($urandom_range(19) == 0) begin
               send_request(CMD_RUN, 8'($urandom_range(255)));
            end else if (done_first < want_first &&
                         (done_second >= want_second || $urandom_range(1) == 1)) begin
               send_request(CMD_LOAD_FIRST, alphabet[$urandom_range(2)]);
               done_first++;
            end else begin
               send_request(CMD_LOAD_SECOND, alphabet[$urandom_range(2)]);
               done_second++;
            end
            sender_gap();
         end
      end
      send_request(CMD_RUN, 8'($urandom_range(255)));
      sender_gap();
   endtask

   // ---------------------------------------------------------------
   // Directed rows. Runs with an obvious answer carry it; the rest are
   // checked against the predictor.
   // ---------------------------------------------------------------
   stim_row_type directed_rows [NUM_ROWS] = '{
      '{CMD_RUN,         8'hA5, 1'b1, EMPTY_RES},   // run straight out of reset
      '{CMD_UNUSED,      8'hFF, 1'b0, NO_RES},
      '{CMD_RUN,         8'h00, 1'b1, EMPTY_RES},   // unused code loaded nothing
      '{CMD_LOAD_FIRST,  8'hFF, 1'b0, NO_RES},
      '{CMD_RUN,         8'hFF, 1'b1, EMPTY_RES},   // second string empty
      '{CMD_LOAD_SECOND, 8'h01, 1'b0, NO_RES},
      '{CMD_RUN,         8'h5A, 1'b1, EMPTY_RES},   // first string empty
      '{CMD_LOAD_FIRST,  8'hFF, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'hFF, 1'b0, NO_RES},
      '{CMD_RUN,         8'h00, 1'b1, '{8'hFF, 1'b1, 7'd1, 1'b0, 1'b1}},
      '{CMD_LOAD_FIRST,  8'h00, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'h00, 1'b0, NO_RES},
      '{CMD_RUN,         8'hFF, 1'b1, '{8'h00, 1'b1, 7'd1, 1'b0, 1'b1}},
      '{CMD_LOAD_FIRST,  8'h12, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'h34, 1'b0, NO_RES},
      '{CMD_RUN,         8'h00, 1'b1, EMPTY_RES},   // no match at all
      // crossed pair: up/left tie decides which symbol survives
      '{CMD_LOAD_FIRST,  8'h0A, 1'b0, NO_RES},
      '{CMD_LOAD_FIRST,  8'h0B, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'h0B, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'h0A, 1'b0, NO_RES},
      '{CMD_RUN,         8'h00, 1'b0, NO_RES},
      // two-symbol result, checks ordering and last
      '{CMD_LOAD_FIRST,  8'h55, 1'b0, NO_RES},
      '{CMD_LOAD_FIRST,  8'hAA, 1'b0, NO_RES},
      '{CMD_LOAD_FIRST,  8'h55, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'hAA, 1'b0, NO_RES},
      '{CMD_LOAD_SECOND, 8'h55, 1'b0, NO_RES},
      '{CMD_RUN,         8'h00, 1'b0, NO_RES}
   };

   // ---------------------------------------------------------------
   // Result checker: every strobe against the oldest owed result.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         got_res = '{rsp_lcs_symbol, rsp_has_symbol, rsp_lcs_length, rsp_overflow, rsp_last};
         strobes_seen++;
         if (expected_subseq.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected strobe sym=%h has=%b len=%0d ovf=%b last=%b",
                        $realtime, got_res.sym, got_res.has_sym, got_res.lcs_len,
                        got_res.overflow, got_res.last);
         end else begin
            want_res = expected_subseq.pop_front();
            if (got_res.sym !== want_res.sym || got_res.has_sym !== want_res.has_sym ||
                got_res.lcs_len !== want_res.lcs_len ||
                got_res.overflow !== want_res.overflow || got_res.last !== want_res.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch exp %h/%b/%0d/%b/%b got %h/%b/%0d/%b/%b",
                           $realtime, want_res.sym, want_res.has_sym, want_res.lcs_len,
                           want_res.overflow, want_res.last, got_res.sym, got_res.has_sym,
                           got_res.lcs_len, got_res.overflow, got_res.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence: directed rows, then three idling regimes of random
   // sequences; the full-size overflow sequence sits in the slow one.
   // ---------------------------------------------------------------
   initial begin
      int unsigned row, s;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 14;
      for (row = 0; row < NUM_ROWS; row++) begin
         send_request(directed_rows[row].cmd, directed_rows[row].sym,
                      directed_rows[row].typed, directed_rows[row].res);
         sender_gap();
      end
      drain_expected();   // sender holds off until nothing is owed

      for (s = 0; s < 3; s++) send_sequence(1'b0);
      drain_expected();

      idle_pct = 86;
      send_sequence(1'b1);
      for (s = 0; s < 2; s++) send_sequence(1'b0);
      drain_expected();

      idle_pct = 0;
      for (s = 0; s < 2; s++) send_sequence(1'b0);
      drain_expected();
      repeat (64) @(posedge clock);   // catch stray strobes

      if (expected_subseq.size() != 0) begin
         $display("%0d expected strobes never arrived", expected_subseq.size());
         mismatches += expected_subseq.size();
      end
      $display("covered %0d requests: %0d runs, %0d dropped loads, %0d strobes checked",
               requests_sent, runs_sent, drops_seen, strobes_seen);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the whole run even if every run were full size.
   initial begin
      #10000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

[sim.f]
sv/lcs_pkg.sv
sv/lcs_ram.sv
sv/lcs_cell.sv
sv/lcs_length_and_backtrack.sv
tb/tb.sv
